[rtl/bhm_pkg.sv]
// Shared types and constants for the Butterworth high-boost mask unit.
// No dependencies; used by every module of the block.
package bhm_pkg;

  localparam int DIM_W = 13;
  localparam int IDX_W = 12;
  localparam int DSQ_W = 26;
  localparam int CUT_W = 16;
  localparam int ORD_W = 4;
  localparam int COEF_W = 16;
  localparam int WORD_W = 32;
  localparam int GAIN_W = 17;

  localparam logic [WORD_W-1:0] Q_CAP = 32'h8000_0000;
  localparam logic [WORD_W-1:0] ONE_Q16 = 32'h0001_0000;

  typedef enum logic [2:0] {
    REG_COLS   = 3'd0,
    REG_ROWS   = 3'd1,
    REG_CUTOFF = 3'd2,
    REG_ORDER  = 3'd3,
    REG_ALPHA  = 3'd4,
    REG_BETA   = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic en;
    logic vld;
  } stage_ctl_t;

endpackage

[rtl/butterworth_highboost_mask_unit.sv]
// Top level of the Butterworth high-boost mask unit: config registers and datapath.
// Depends on bhm_pkg, bhm_div_pipe and bhm_pow_pipe.
//
//   channel | direction | handshake            | payload
//   in      | input     | in_valid / in_stall   | in_col_index, in_row_index
//   out     | output    | out_valid / out_stall | out_coefficient
//   cfg     | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One item enters per clock unless the output stalls; the path runs through the three
// bit-per-stage divider levels (32, 32 and 17 stages) and the power multiplier chain.
// A stalled output holds the whole pipeline in place; bubbles are not squeezed out.
// Synchronous active-low reset clears valid bits and restores register defaults.
// Dims, cutoff and order are clamped or squared in registers; cfg_ready is always high.
module butterworth_highboost_mask_unit #(
  parameter int MAX_DIM   = 4096,
  parameter int MAX_ORDER = 8
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [bhm_pkg::IDX_W-1:0]    in_col_index,
  input  logic [bhm_pkg::IDX_W-1:0]    in_row_index,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [bhm_pkg::COEF_W-1:0] out_coefficient,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [2:0]                   cfg_index,
  input  logic [15:0]                  cfg_data
);

  localparam int POW_ST = (MAX_ORDER > 1) ? MAX_ORDER - 1 : 1;

  logic [bhm_pkg::DIM_W-1:0] cols_cfg_r, rows_cfg_r;
  logic [bhm_pkg::CUT_W-1:0] cut_cfg_r;
  logic [bhm_pkg::ORD_W-1:0] order_cfg_r;
  logic [15:0]               alpha_r, beta_r;

  logic [bhm_pkg::DIM_W-1:0] cols_c_r, rows_c_r, cols_c_nxt, rows_c_nxt;
  logic [bhm_pkg::DSQ_W-1:0] cols_sq_r, rows_sq_r;
  logic [31:0]               cut_sq_r;
  logic [15:0]               cut_c;
  logic [4:0]                order_c_r, order_c_nxt;

  logic adv;
  bhm_pkg::stage_ctl_t ctl_d1, ctl_d2, ctl_pw, ctl_d3;

  logic                       s0_vld_r, s1_vld_r, s2_vld_r, s3_vld_r, s4_vld_r, out_vld_r;
  logic [bhm_pkg::IDX_W-1:0]  dc_r, dr_r, dc_nxt, dr_nxt;
  logic [bhm_pkg::DIM_W-1:0]  ic, ir, half_c, half_r, up_c, up_r;
  logic [23:0]                dsq_c_r, dsq_r_r;

  logic                       d1c_vld, d1r_vld;
  logic [31:0]                term_c, term_r;
  logic [31:0]                r2_r, r2_nxt;
  logic                       sat_r, sat_nxt;
  logic [31:0]                rem2, den2, low2;
  logic                       d2_vld;
  logic [31:0]                t_q;
  logic                       pw_vld;
  logic [31:0]                p_q;
  logic [31:0]                d3_den_r, d3_rem_r, den3;
  logic [16:0]                d3_low_r;
  logic [47:0]                num3;
  logic                       d3_vld;
  logic [16:0]                g_q;
  logic signed [33:0]         prod_r, rnd;
  logic signed [17:0]         v_sh;
  logic signed [18:0]         sum;
  logic signed [15:0]         coef_r, coef_nxt;

  assign adv       = !out_vld_r || !out_stall;
  assign in_stall  = !adv;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_cfg_r  <= 13'd256;
      rows_cfg_r  <= 13'd256;
      cut_cfg_r   <= 16'd6554;
      order_cfg_r <= 4'd2;
      alpha_r     <= 16'd8192;
      beta_r      <= 16'd2048;
    end else if (cfg_valid && cfg_ready) begin
      unique case (bhm_pkg::cfg_reg_t'(cfg_index))
        bhm_pkg::REG_COLS:   cols_cfg_r  <= cfg_data[12:0];
        bhm_pkg::REG_ROWS:   rows_cfg_r  <= cfg_data[12:0];
        bhm_pkg::REG_CUTOFF: cut_cfg_r   <= cfg_data;
        bhm_pkg::REG_ORDER:  order_cfg_r <= cfg_data[3:0];
        bhm_pkg::REG_ALPHA:  alpha_r     <= cfg_data;
        bhm_pkg::REG_BETA:   beta_r      <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (cols_cfg_r == '0) begin
      cols_c_nxt = 13'd1;
    end else if (32'(cols_cfg_r) > MAX_DIM) begin
      cols_c_nxt = 13'(MAX_DIM);
    end else begin
      cols_c_nxt = cols_cfg_r;
    end
    if (rows_cfg_r == '0) begin
      rows_c_nxt = 13'd1;
    end else if (32'(rows_cfg_r) > MAX_DIM) begin
      rows_c_nxt = 13'(MAX_DIM);
    end else begin
      rows_c_nxt = rows_cfg_r;
    end
    cut_c = (cut_cfg_r == '0) ? 16'd1 : cut_cfg_r;
    if (order_cfg_r == '0) begin
      order_c_nxt = 5'd1;
    end else if (32'(order_cfg_r) > MAX_ORDER) begin
      order_c_nxt = 5'(MAX_ORDER);
    end else begin
      order_c_nxt = 5'(order_cfg_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_c_r  <= 13'd256;
      rows_c_r  <= 13'd256;
      cols_sq_r <= 26'd65536;
      rows_sq_r <= 26'd65536;
      cut_sq_r  <= 32'd42954916;
      order_c_r <= 5'd2;
    end else begin
      cols_c_r  <= cols_c_nxt;
      rows_c_r  <= rows_c_nxt;
      cols_sq_r <= {13'b0, cols_c_r} * {13'b0, cols_c_r};
      rows_sq_r <= {13'b0, rows_c_r} * {13'b0, rows_c_r};
      cut_sq_r  <= {16'b0, cut_c} * {16'b0, cut_c};
      order_c_r <= order_c_nxt;
    end
  end

  always_comb begin
    ic     = ({1'b0, in_col_index} >= cols_c_r) ? cols_c_r - 13'd1 : {1'b0, in_col_index};
    ir     = ({1'b0, in_row_index} >= rows_c_r) ? rows_c_r - 13'd1 : {1'b0, in_row_index};
    half_c = cols_c_r >> 1;
    half_r = rows_c_r >> 1;
    up_c   = cols_c_r - half_c;
    up_r   = rows_c_r - half_r;
    dc_nxt = (ic < up_c) ? ic[11:0] : 12'(cols_c_r - ic);
    dr_nxt = (ir < up_r) ? ir[11:0] : 12'(rows_c_r - ir);
  end

  always_comb begin
    r2_nxt  = term_c + term_r;
    sat_nxt = ({15'b0, r2_nxt} >= {cut_sq_r, 15'b0});
    rem2    = sat_r ? 32'd1 : {16'b0, r2_r[31:16]};
    den2    = sat_r ? 32'd2 : cut_sq_r;
    low2    = sat_r ? 32'd0 : {r2_r[15:0], 16'b0};
    den3    = p_q + bhm_pkg::ONE_Q16;
    num3    = {p_q, 16'b0} + 48'(den3 >> 1);
    rnd     = prod_r + 34'sd32768;
    v_sh    = rnd[33:16];
    sum     = {v_sh[17], v_sh} + {{3{beta_r[15]}}, beta_r};
    if (sum > 19'sd32767) begin
      coef_nxt = 16'sh7FFF;
    end else if (sum < -19'sd32768) begin
      coef_nxt = -16'sh8000;
    end else begin
      coef_nxt = sum[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r  <= 1'b0;
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      s3_vld_r  <= 1'b0;
      s4_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (adv) begin
      s0_vld_r  <= in_valid;
      s1_vld_r  <= s0_vld_r;
      s2_vld_r  <= d1c_vld;
      s3_vld_r  <= pw_vld;
      s4_vld_r  <= d3_vld;
      out_vld_r <= s4_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dc_r     <= dc_nxt;
      dr_r     <= dr_nxt;
      dsq_c_r  <= {12'b0, dc_r} * {12'b0, dc_r};
      dsq_r_r  <= {12'b0, dr_r} * {12'b0, dr_r};
      r2_r     <= r2_nxt;
      sat_r    <= sat_nxt;
      d3_rem_r <= {1'b0, num3[47:17]};
      d3_low_r <= num3[16:0];
      d3_den_r <= den3;
      prod_r   <= $signed({{18{alpha_r[15]}}, alpha_r}) * $signed({17'b0, g_q});
      coef_r   <= coef_nxt;
    end
  end

  assign ctl_d1 = '{en: adv, vld: s1_vld_r};
  assign ctl_d2 = '{en: adv, vld: s2_vld_r};
  assign ctl_pw = '{en: adv, vld: d2_vld};
  assign ctl_d3 = '{en: adv, vld: s3_vld_r};

  bhm_div_pipe #(.DW(bhm_pkg::DSQ_W), .QW(32)) u_div_col (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl_i (ctl_d1),
    .rem_i ({2'b0, dsq_c_r}),
    .low_i (32'd0),
    .den_i (cols_sq_r),
    .vld_o (d1c_vld),
    .quo_o (term_c)
  );

  bhm_div_pipe #(.DW(bhm_pkg::DSQ_W), .QW(32)) u_div_row (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl_i (ctl_d1),
    .rem_i ({2'b0, dsq_r_r}),
    .low_i (32'd0),
    .den_i (rows_sq_r),
    .vld_o (d1r_vld),
    .quo_o (term_r)
  );

  bhm_div_pipe #(.DW(32), .QW(32)) u_div_ratio (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl_i (ctl_d2),
    .rem_i (rem2),
    .low_i (low2),
    .den_i (den2),
    .vld_o (d2_vld),
    .quo_o (t_q)
  );

  bhm_pow_pipe #(.NST(POW_ST)) u_pow (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl_i   (ctl_pw),
    .t_i     (t_q),
    .order_i (order_c_r),
    .vld_o   (pw_vld),
    .p_o     (p_q)
  );

  bhm_div_pipe #(.DW(32), .QW(bhm_pkg::GAIN_W)) u_div_gain (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl_i (ctl_d3),
    .rem_i (d3_rem_r),
    .low_i (d3_low_r),
    .den_i (d3_den_r),
    .vld_o (d3_vld),
    .quo_o (g_q)
  );

  assign out_valid       = out_vld_r;
  assign out_coefficient = coef_r;

`ifndef SYNTHESIS
  a_axis_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    d1c_vld == d1r_vld) else $error("axis dividers out of step");
  a_ratio_cap: assert property (@(posedge clk) disable iff (!rst_n)
    d2_vld |-> t_q <= bhm_pkg::Q_CAP) else $error("ratio above cap");
  a_gain_range: assert property (@(posedge clk) disable iff (!rst_n)
    d3_vld |-> g_q <= 17'h10000) else $error("gain above one");
  a_cut_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    cut_sq_r != 32'd0) else $error("zero cutoff square");
  a_order_range: assert property (@(posedge clk) disable iff (!rst_n)
    order_c_r >= 5'd1 && 32'(order_c_r) <= MAX_ORDER) else $error("order out of range");
`endif

endmodule

[rtl/bhm_div_pipe.sv]
// Pipelined restoring divider, one quotient bit per register stage.
// Depends on bhm_pkg for the stage control struct.
module bhm_div_pipe #(
  parameter int DW = 32,
  parameter int QW = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  bhm_pkg::stage_ctl_t ctl_i,
  input  logic [DW-1:0]       rem_i,
  input  logic [QW-1:0]       low_i,
  input  logic [DW-1:0]       den_i,
  output logic                vld_o,
  output logic [QW-1:0]       quo_o
);

  logic [DW-1:0] rem_r [QW];
  logic [DW-1:0] den_r [QW];
  logic [QW-1:0] low_r [QW];
  logic [QW-1:0] quo_r [QW];
  logic [QW-1:0] vld_r;

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [DW-1:0] rem_p;
    logic [DW-1:0] den_p;
    logic [QW-1:0] low_p;
    logic [QW-1:0] quo_p;
    logic          vld_p;
    logic [DW:0]   trial;
    logic          take;
    logic [DW-1:0] rem_nxt;
    logic [QW-1:0] low_nxt;
    logic [QW-1:0] quo_nxt;

    if (k == 0) begin : g_first
      assign rem_p = rem_i;
      assign den_p = den_i;
      assign low_p = low_i;
      assign quo_p = '0;
      assign vld_p = ctl_i.vld;
    end else begin : g_next
      assign rem_p = rem_r[k-1];
      assign den_p = den_r[k-1];
      assign low_p = low_r[k-1];
      assign quo_p = quo_r[k-1];
      assign vld_p = vld_r[k-1];
    end

    always_comb begin
      trial   = {rem_p, low_p[QW-1]};
      take    = (trial >= {1'b0, den_p});
      rem_nxt = take ? DW'(trial - {1'b0, den_p}) : DW'(trial);
      low_nxt = {low_p[QW-2:0], 1'b0};
      quo_nxt = {quo_p[QW-2:0], take};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (ctl_i.en) begin
        vld_r[k] <= vld_p;
      end
    end

    always_ff @(posedge clk) begin
      if (ctl_i.en) begin
        rem_r[k] <= rem_nxt;
        den_r[k] <= den_p;
        low_r[k] <= low_nxt;
        quo_r[k] <= quo_nxt;
      end
    end
  end

  assign vld_o = vld_r[QW-1];
  assign quo_o = quo_r[QW-1];

endmodule

[rtl/bhm_pow_pipe.sv]
// Power stages: raise t to the order, one capped Q.16 multiply per stage up to the order.
// Depends on bhm_pkg for widths, the cap constant and the stage control struct.
module bhm_pow_pipe #(
  parameter int NST = 7
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  bhm_pkg::stage_ctl_t               ctl_i,
  input  logic [bhm_pkg::WORD_W-1:0]        t_i,
  input  logic [4:0]                        order_i,
  output logic                              vld_o,
  output logic [bhm_pkg::WORD_W-1:0]        p_o
);

  logic [bhm_pkg::WORD_W-1:0] p_r [NST];
  logic [bhm_pkg::WORD_W-1:0] t_r [NST];
  logic [NST-1:0]             vld_r;

  for (genvar k = 0; k < NST; k++) begin : g_stage
    logic [bhm_pkg::WORD_W-1:0]   p_p;
    logic [bhm_pkg::WORD_W-1:0]   t_p;
    logic                         vld_p;
    logic [2*bhm_pkg::WORD_W-1:0] prod;
    logic [47:0]                  shifted;
    logic                         apply;
    logic [bhm_pkg::WORD_W-1:0]   p_nxt;

    if (k == 0) begin : g_first
      assign p_p   = t_i;
      assign t_p   = t_i;
      assign vld_p = ctl_i.vld;
    end else begin : g_next
      assign p_p   = p_r[k-1];
      assign t_p   = t_r[k-1];
      assign vld_p = vld_r[k-1];
    end

    always_comb begin
      prod    = {32'b0, p_p} * {32'b0, t_p};
      shifted = prod[63:16];
      apply   = (5'(k + 1) < order_i);
      if (!apply) begin
        p_nxt = p_p;
      end else if (shifted > 48'(bhm_pkg::Q_CAP)) begin
        p_nxt = bhm_pkg::Q_CAP;
      end else begin
        p_nxt = shifted[31:0];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (ctl_i.en) begin
        vld_r[k] <= vld_p;
      end
    end

    always_ff @(posedge clk) begin
      if (ctl_i.en) begin
        p_r[k] <= p_nxt;
        t_r[k] <= t_p;
      end
    end
  end

  assign vld_o = vld_r[NST-1];
  assign p_o   = p_r[NST-1];

endmodule
